// ===== rtl/core/sha512_256_hash_core_macros.svh =====
// Assertion macros for the hash core checker.
`ifndef SHA512_256_HASH_CORE_MACROS_SVH
`define SHA512_256_HASH_CORE_MACROS_SVH

// Assert that an implication holds on every clock edge outside reset.
`define SHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that a condition implies another in the next cycle.
`define SHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/shc_pkg.sv =====
`default_nettype none
package shc_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  valid_bytes;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Control between the sequencer and the round unit.
  typedef struct packed {
    logic start;
    logic done;
  } rnd_ctl_t;

  localparam logic [63:0] InitChain [8] = '{
    64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2,
    64'h2393B86B6F53B151, 64'h963877195940EABD,
    64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992,
    64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
  };

  localparam logic [63:0] RoundConst [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/shc_round.sv =====
`default_nettype none
// One compression round per cycle, with the rolling schedule.
module shc_round (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               wr_i,
  input  logic [3:0]         wr_idx_i,
  input  logic [63:0]        wr_data_i,
  input  logic [63:0]        chain_i [8],
  output logic [63:0]        vars_o [8],
  output logic               done_o
);
  import shc_pkg::*;

  logic [63:0] w_q [16];
  logic [63:0] v_q [8];
  logic [63:0] v_d [8];
  logic [6:0]  t_q;
  logic        busy_q;
  logic [3:0]  ti, t15, t2, t7;
  logic [63:0] x15, x2, wt, s1, ch, t1, s0, mj;

  assign ti  = t_q[3:0];
  assign t15 = ti - 4'd15;
  assign t2  = ti - 4'd2;
  assign t7  = ti - 4'd7;
  assign x15 = w_q[t15];
  assign x2  = w_q[t2];

  // Schedule word and round function.
  always_comb begin
    if (t_q < 7'(BlockWords)) begin
      wt = w_q[ti];
    end else begin
      wt = w_q[ti] + (rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7)) + w_q[t7]
         + (rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6));
    end
    s1 = rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + RoundConst[t_q] + wt;
    s0 = rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    v_d[0] = t1 + s0 + mj;
    v_d[1] = v_q[0];
    v_d[2] = v_q[1];
    v_d[3] = v_q[2];
    v_d[4] = v_q[3] + t1;
    v_d[5] = v_q[4];
    v_d[6] = v_q[5];
    v_d[7] = v_q[6];
  end

  // Round counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      t_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      t_q    <= '0;
    end else if (busy_q) begin
      if (t_q == 7'(Rounds - 1)) busy_q <= 1'b0;
      else t_q <= t_q + 7'd1;
    end
  end

  // Working variables and schedule window.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= chain_i;
    end else if (busy_q) begin
      v_q <= v_d;
      w_q[ti] <= wt;
    end
    if (wr_i) w_q[wr_idx_i] <= wr_data_i;
  end

  assign done_o = busy_q && (t_q == 7'(Rounds - 1));
  assign vars_o = v_d;
endmodule
`default_nettype wire

// ===== rtl/core/sha512_256_hash_core.sv =====
`default_nettype none
// Channel | Direction | Payload
// in      | input     | shc_pkg::in_item_t  (in_valid_i, in_stall_o)
// out     | output    | shc_pkg::out_item_t (out_valid_o, out_stall_i)
// A plain word is taken in its accepting cycle; a word that fills a block also starts
// the rounds in the shared round unit, with the chain update on the last round's edge.
// A last word adds padding words at one a cycle, save while a compression runs, one or
// two compressions, and then four result items.
// Reset restores the initial chain value; the schedule window is not cleared.
// The input stalls while padding, compressing or delivering results.
module sha512_256_hash_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  shc_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output shc_pkg::out_item_t  out_item_o
);
  import shc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_OUT  = 5'b01000,
    ST_LEN  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] chain_q [8];
  logic [63:0] vars [8];
  logic [63:0] bits_q;
  logic [3:0]  pos_q;
  logic        fin_q;   // message ended, padding in progress
  logic        extra_q; // a 0x80 word is still owed (full last word)
  logic        len_q;   // length word written, final compression running
  logic [1:0]  oidx_q;
  rnd_ctl_t    ctl;
  logic        rnd_done;
  logic        wr;
  logic [63:0] wdata;
  logic [3:0]  vb;
  logic [63:0] mask, padw;
  logic        acc;

  assign acc = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign vb = (in_item_i.valid_bytes > 4'd8) ? 4'd8 : in_item_i.valid_bytes;
  assign mask = (vb == 4'd0) ? 64'd0 : ~64'd0 << (7'd64 - {vb, 3'b000});
  assign padw = (in_item_i.data & mask) | (64'h80 << (6'd56 - {vb[2:0], 3'b000}));

  // Word written into the schedule window this cycle.
  always_comb begin
    wr = 1'b0;
    wdata = '0;
    if (acc) begin
      wr = 1'b1;
      wdata = (!in_item_i.last || vb == 4'd8) ? in_item_i.data : padw;
    end else if (state_q == ST_PAD) begin
      wr = 1'b1;
      wdata = extra_q ? 64'h8000_0000_0000_0000 : 64'd0;
    end else if (state_q == ST_LEN) begin
      wr = 1'b1;
      wdata = bits_q;
    end
  end

  assign ctl = '{start: wr && (pos_q == 4'd15), done: rnd_done};

  shc_round u_round (
    .clk_i, .rst_ni,
    .start_i   (ctl.start),
    .wr_i      (wr),
    .wr_idx_i  (pos_q),
    .wr_data_i (wdata),
    .chain_i   (chain_q),
    .vars_o    (vars),
    .done_o    (rnd_done)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (acc) begin
        if (pos_q == 4'd15) state_d = ST_COMP;
        else if (in_item_i.last) state_d = ST_PAD;
      end
      ST_PAD: begin
        if (pos_q == 4'd15) state_d = ST_COMP;
        else if (pos_q == 4'd14 && !extra_q) state_d = ST_LEN;
      end
      ST_LEN:  state_d = ST_COMP;
      ST_COMP: if (ctl.done) begin
        if (!fin_q) state_d = ST_IDLE;
        else if (!len_q) state_d = ST_PAD;
        else state_d = ST_OUT;
      end
      ST_OUT: if (!out_stall_i && oidx_q == 2'd3) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chain_q <= InitChain;
      bits_q  <= '0;
      pos_q   <= '0;
      fin_q   <= 1'b0;
      extra_q <= 1'b0;
      len_q   <= 1'b0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      if (wr) pos_q <= pos_q + 4'd1;
      if (acc) begin
        bits_q <= bits_q + (in_item_i.last ? {57'd0, vb, 3'b000} : 64'd64);
        fin_q  <= in_item_i.last;
        extra_q <= in_item_i.last && vb == 4'd8;
      end else if (state_q == ST_PAD) begin
        extra_q <= 1'b0;
      end
      if (state_q == ST_LEN) len_q <= 1'b1;
      if (ctl.done) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + vars[i];
      end
      if (state_q == ST_OUT && !out_stall_i) begin
        oidx_q <= oidx_q + 2'd1;
        if (oidx_q == 2'd3) begin
          chain_q <= InitChain;
          bits_q  <= '0;
          pos_q   <= '0;
          fin_q   <= 1'b0;
          len_q   <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign out_item_o.digest_word = chain_q[oidx_q];
  assign out_item_o.word_index  = oidx_q;
  assign out_item_o.last_word   = (oidx_q == 2'd3);
endmodule
`default_nettype wire

// ===== rtl/core/shc_checker.sv =====
`default_nettype none
`include "sha512_256_hash_core_macros.svh"
// Port-level checks on the hash core.
module shc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input shc_pkg::out_item_t out_item_o,
  input logic               out_valid_o,
  input logic               out_stall_i
);
  // No input is taken while results are shown.
  `SHC_ASSERT_IMP(a_out_blocks_in, clk_i, rst_ni, out_valid_o, in_stall_o)
  // A stalled result holds.
  `SHC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_item_o))
  // The final flag marks the fourth word only.
  `SHC_ASSERT_IMP(a_lastw, clk_i, rst_ni, out_valid_o,
                  out_item_o.last_word == (out_item_o.word_index == 2'd3))
  // The index advances by one after each taken non-final word.
  `SHC_ASSERT_NEXT(a_step, clk_i, rst_ni,
                   out_valid_o && !out_stall_i && !out_item_o.last_word,
                   out_valid_o && out_item_o.word_index == $past(out_item_o.word_index) + 2'd1)
endmodule

bind sha512_256_hash_core shc_checker u_shc_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_item_o, .out_valid_o, .out_stall_i
);
`default_nettype wire
